FILE: hdl/fcb_pkg.sv
// shared types, constants and helper functions of the follow camera basis block
package fcb_pkg;

   localparam int ReqDataWidth = 112;
   localparam int RspDataWidth = 288;
   localparam int CsrAddrWidth = 1;
   localparam int CsrDataWidth = 32;
   localparam int CordicSteps  = 15;
   localparam int StepWidth    = 4;

   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   localparam logic signed [15:0] OneQ14     = 16'sd16384;

   localparam logic [30:0] OffsetReset = 31'd231702;
   localparam logic [31:0] HeightReset = 32'd128743;

   // register indexes on the configuration port
   localparam logic [CsrAddrWidth-1:0] RegOffset = 1'b0;
   localparam logic [CsrAddrWidth-1:0] RegHeight = 1'b1;

   typedef enum logic [1:0] {
      JOB_HEAD,
      JOB_ANG,
      JOB_PIT
   } job_type;

   typedef enum logic [2:0] {
      MOP_OFFC,
      MOP_OFFS,
      MOP_CC,
      MOP_SC,
      MOP_CSP,
      MOP_SSP
   } mop_type;

   typedef struct packed {
      logic                 cap;
      logic                 cor_init;
      logic                 cor_step;
      logic                 cor_save;
      job_type              job;
      logic [StepWidth-1:0] step;
      logic                 mul_go;
      logic                 mul_wr;
      mop_type              mop;
      logic                 out_load;
   } cmd_type;

   function automatic logic signed [17:0] atan_units(input logic [StepWidth-1:0] i);
      logic signed [17:0] v;
      unique case (i)
         4'd0:    v = 18'sd8192;
         4'd1:    v = 18'sd4836;
         4'd2:    v = 18'sd2555;
         4'd3:    v = 18'sd1297;
         4'd4:    v = 18'sd651;
         4'd5:    v = 18'sd326;
         4'd6:    v = 18'sd163;
         4'd7:    v = 18'sd81;
         4'd8:    v = 18'sd41;
         4'd9:    v = 18'sd20;
         4'd10:   v = 18'sd10;
         4'd11:   v = 18'sd5;
         4'd12:   v = 18'sd3;
         4'd13:   v = 18'sd1;
         4'd14:   v = 18'sd1;
         default: v = 18'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -35'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/follow_camera_basis.sv
// Follow camera basis: a move word (tuser 0) places the camera behind the vehicle at the
// configured offset and height; a look word (tuser 1) stores a new yaw and pitch. Every word
// yields one result word with position, unit direction, unit up and look-at target. From
// acceptance to the result register, a move takes three and a look two passes of a shared
// 15-step cordic unit, plus six or four passes of one shared 32x16 multiplier, and then the
// result is loaded once the rsp side is free. A new word is taken while the previous result
// still waits on the rsp side. Configuration writes are taken any time and must only be
// issued while the block is idle.
module follow_camera_basis (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // vehicle_x, vehicle_z, heading, yaw, pitch
   input  logic [fcb_pkg::ReqDataWidth-1:0]      req_tdata,
   // kind
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, up_x, up_y, up_z, target_x, target_y, target_z
   output logic [fcb_pkg::RspDataWidth-1:0]      rsp_tdata,
   input  logic                                  csr_we,
   input  logic [fcb_pkg::CsrAddrWidth-1:0]      csr_addr,
   input  logic [fcb_pkg::CsrDataWidth-1:0]      csr_wdata
);

   fcb_pkg::cmd_type cmd;

   fcb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   fcb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

FILE: hdl/fcb_ctrl.sv
// sequencer of the follow camera basis: cordic passes, multiplies and result handoff
module fcb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_kind,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output fcb_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CINIT,
      S_CRUN,
      S_CSAVE,
      S_MUL,
      S_MWR,
      S_OUT
   } state_type;

   state_type                       state_ff, state_in;
   fcb_pkg::job_type                job_ff, job_in;
   fcb_pkg::mop_type                mop_ff, mop_in;
   logic [fcb_pkg::StepWidth-1:0]   cnt_ff, cnt_in;
   logic                            valid_ff, valid_in;
   logic                            out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign out_free   = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      mop_in   = mop_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      cmd          = '0;
      cmd.job      = job_ff;
      cmd.mop      = mop_ff;
      cmd.step     = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.cap  = 1'b1;
               job_in   = req_kind ? fcb_pkg::JOB_ANG : fcb_pkg::JOB_HEAD;
               // capture follows the kind of the incoming word
               cmd.job  = job_in;
               state_in = S_CINIT;
            end
         end
         S_CINIT: begin
            cmd.cor_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_CRUN;
         end
         S_CRUN: begin
            cmd.cor_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == fcb_pkg::StepWidth'(fcb_pkg::CordicSteps - 1)) begin
               state_in = S_CSAVE;
            end
         end
         S_CSAVE: begin
            cmd.cor_save = 1'b1;
            unique case (job_ff)
               fcb_pkg::JOB_HEAD: begin
                  mop_in   = fcb_pkg::MOP_OFFC;
                  state_in = S_MUL;
               end
               fcb_pkg::JOB_ANG: begin
                  job_in   = fcb_pkg::JOB_PIT;
                  state_in = S_CINIT;
               end
               default: begin
                  mop_in   = fcb_pkg::MOP_CC;
                  state_in = S_MUL;
               end
            endcase
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = S_MWR;
         end
         S_MWR: begin
            cmd.mul_wr = 1'b1;
            unique case (mop_ff)
               fcb_pkg::MOP_OFFC: begin
                  mop_in   = fcb_pkg::MOP_OFFS;
                  state_in = S_MUL;
               end
               fcb_pkg::MOP_OFFS: begin
                  job_in   = fcb_pkg::JOB_ANG;
                  state_in = S_CINIT;
               end
               fcb_pkg::MOP_CC: begin
                  mop_in   = fcb_pkg::MOP_SC;
                  state_in = S_MUL;
               end
               fcb_pkg::MOP_SC: begin
                  mop_in   = fcb_pkg::MOP_CSP;
                  state_in = S_MUL;
               end
               fcb_pkg::MOP_CSP: begin
                  mop_in   = fcb_pkg::MOP_SSP;
                  state_in = S_MUL;
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         job_ff   <= fcb_pkg::JOB_HEAD;
         mop_ff   <= fcb_pkg::MOP_OFFC;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         mop_ff   <= mop_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: hdl/fcb_datapath.sv
// datapath of the follow camera basis: shared cordic, shared multiplier, state and result word
module fcb_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fcb_pkg::cmd_type                      cmd,
   input  logic [fcb_pkg::ReqDataWidth-1:0]      req_tdata,
   input  logic                                  csr_we,
   input  logic [fcb_pkg::CsrAddrWidth-1:0]      csr_addr,
   input  logic [fcb_pkg::CsrDataWidth-1:0]      csr_wdata,
   output logic [fcb_pkg::RspDataWidth-1:0]      rsp_tdata
);

   logic [30:0]        off_ff;
   logic signed [31:0] height_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [15:0]        yaw_ff, heading_ff;
   logic signed [15:0] pitch_ff;
   logic signed [31:0] veh_x_ff, veh_z_ff;

   logic signed [33:0] x_ff, y_ff;
   logic signed [17:0] z_ff;
   logic [1:0]         quad_ff;
   logic               zero_ff;

   logic signed [15:0] s_head_ff, c_head_ff, s_ang_ff, c_ang_ff, s_pit_ff, c_pit_ff;
   logic signed [15:0] cc_ff, sc_ff, csp_ff, ssp_ff;
   logic signed [47:0] prod_ff;
   logic [fcb_pkg::RspDataWidth-1:0] rsp_ff;

   // cordic init
   logic [15:0]        ang;
   logic [15:0]        ang_bias;
   logic [1:0]         quad;
   logic [15:0]        resid;

   // cordic step
   logic signed [33:0] dx, dy;
   logic signed [17:0] at;

   // cordic finish
   logic signed [33:0] xr_full, yr_full;
   logic signed [17:0] xr, yr;
   logic signed [15:0] cx, sy, cs_out, sn_out;

   // multiplier
   logic signed [31:0] mul_a;
   logic signed [15:0] mul_b;
   logic signed [47:0] rnd_full;
   logic signed [33:0] rnd;
   logic signed [34:0] pos_diff_x, pos_diff_z;

   // result
   logic signed [15:0] up_x, up_y, up_z;
   logic signed [31:0] tgt_x, tgt_y, tgt_z;

   assign rsp_tdata = rsp_ff;

   always_comb begin
      unique case (cmd.job)
         fcb_pkg::JOB_HEAD: ang = heading_ff;
         fcb_pkg::JOB_ANG:  ang = yaw_ff + heading_ff;
         default:           ang = pitch_ff;
      endcase
      ang_bias = ang + 16'd8192;
      quad     = ang_bias[15:14];
      resid    = ang - {quad, 14'd0};
   end

   // x moves by the shifted y term, y by the shifted x term
   assign dx = y_ff >>> cmd.step;
   assign dy = x_ff >>> cmd.step;
   assign at = fcb_pkg::atan_units(cmd.step);

   function automatic logic signed [15:0] clamp_unit(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd16384) begin
         r = fcb_pkg::OneQ14;
      end else if (v < -18'sd16384) begin
         r = -fcb_pkg::OneQ14;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   always_comb begin
      xr_full = (x_ff + 34'sd32768) >>> 16;
      yr_full = (y_ff + 34'sd32768) >>> 16;
      xr      = xr_full[17:0];
      yr      = yr_full[17:0];
      if (zero_ff) begin
         cx = fcb_pkg::OneQ14;
         sy = '0;
      end else begin
         cx = clamp_unit(xr);
         sy = clamp_unit(yr);
      end
      unique case (quad_ff)
         2'd0: begin cs_out = cx;  sn_out = sy;  end
         2'd1: begin cs_out = -sy; sn_out = cx;  end
         2'd2: begin cs_out = -cx; sn_out = -sy; end
         default: begin cs_out = sy; sn_out = -cx; end
      endcase
   end

   always_comb begin
      unique case (cmd.mop)
         fcb_pkg::MOP_OFFC: begin mul_a = {1'b0, off_ff}; mul_b = c_head_ff; end
         fcb_pkg::MOP_OFFS: begin mul_a = {1'b0, off_ff}; mul_b = s_head_ff; end
         fcb_pkg::MOP_CC:   begin mul_a = 32'(c_ang_ff);  mul_b = c_pit_ff;  end
         fcb_pkg::MOP_SC:   begin mul_a = 32'(s_ang_ff);  mul_b = c_pit_ff;  end
         fcb_pkg::MOP_CSP:  begin mul_a = 32'(c_ang_ff);  mul_b = s_pit_ff;  end
         default:           begin mul_a = 32'(s_ang_ff);  mul_b = s_pit_ff;  end
      endcase
      rnd_full   = (prod_ff + 48'sd8192) >>> 14;
      rnd        = rnd_full[33:0];
      pos_diff_x = 35'(veh_x_ff) - 35'(rnd);
      pos_diff_z = 35'(veh_z_ff) - 35'(rnd);
   end

   always_comb begin
      // up has no direction when cos(pitch) is zero
      if (c_pit_ff == 16'sd0) begin
         up_x = '0;
         up_y = '0;
         up_z = '0;
      end else if (c_pit_ff > 16'sd0) begin
         up_x = -csp_ff;
         up_y = c_pit_ff;
         up_z = -ssp_ff;
      end else begin
         up_x = csp_ff;
         up_y = -c_pit_ff;
         up_z = ssp_ff;
      end
      tgt_x = fcb_pkg::sat32(35'(pos_x_ff) + 35'(cc_ff) * 35'sd4);
      tgt_y = fcb_pkg::sat32(35'(pos_y_ff) + 35'(s_pit_ff) * 35'sd4);
      tgt_z = fcb_pkg::sat32(35'(pos_z_ff) + 35'(sc_ff) * 35'sd4);
   end

   // configuration and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff     <= fcb_pkg::OffsetReset;
         height_ff  <= fcb_pkg::HeightReset;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         pos_z_ff   <= '0;
         yaw_ff     <= '0;
         pitch_ff   <= '0;
         heading_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               fcb_pkg::RegOffset: off_ff    <= csr_wdata[30:0];
               default:            height_ff <= csr_wdata;
            endcase
         end
         if (cmd.cap) begin
            if (cmd.job == fcb_pkg::JOB_HEAD) begin
               heading_ff <= req_tdata[79:64];
            end else begin
               yaw_ff   <= req_tdata[95:80];
               pitch_ff <= req_tdata[111:96];
            end
         end
         if (cmd.mul_wr && cmd.mop == fcb_pkg::MOP_OFFC) begin
            pos_x_ff <= fcb_pkg::sat32(pos_diff_x);
         end
         if (cmd.mul_wr && cmd.mop == fcb_pkg::MOP_OFFS) begin
            pos_y_ff <= height_ff;
            pos_z_ff <= fcb_pkg::sat32(pos_diff_z);
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         veh_x_ff <= req_tdata[31:0];
         veh_z_ff <= req_tdata[63:32];
      end
      if (cmd.cor_init) begin
         x_ff    <= fcb_pkg::CordicGain;
         y_ff    <= '0;
         z_ff    <= 18'(signed'(resid));
         quad_ff <= quad;
         zero_ff <= (resid == 16'd0);
      end else if (cmd.cor_step) begin
         if (!z_ff[17]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end
      end
      if (cmd.cor_save) begin
         unique case (cmd.job)
            fcb_pkg::JOB_HEAD: begin s_head_ff <= sn_out; c_head_ff <= cs_out; end
            fcb_pkg::JOB_ANG:  begin s_ang_ff  <= sn_out; c_ang_ff  <= cs_out; end
            default:           begin s_pit_ff  <= sn_out; c_pit_ff  <= cs_out; end
         endcase
      end
      if (cmd.mul_go) begin
         prod_ff <= 48'(mul_a) * 48'(mul_b);
      end
      if (cmd.mul_wr) begin
         unique case (cmd.mop)
            fcb_pkg::MOP_CC:  cc_ff  <= rnd[15:0];
            fcb_pkg::MOP_SC:  sc_ff  <= rnd[15:0];
            fcb_pkg::MOP_CSP: csp_ff <= rnd[15:0];
            fcb_pkg::MOP_SSP: ssp_ff <= rnd[15:0];
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         rsp_ff <= {tgt_z, tgt_y, tgt_x, up_z, up_y, up_x,
                    sc_ff, s_pit_ff, cc_ff, pos_z_ff, pos_y_ff, pos_x_ff};
      end
   end

endmodule

FILE: verif/tb_follow_camera_basis.sv
// self-checking testbench of the follow camera basis block
module tb_follow_camera_basis;

   localparam int NumRandom = 400;

   typedef struct packed {
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic signed [15:0] dir_x, dir_y, dir_z;
      logic signed [15:0] up_x, up_y, up_z;
      logic signed [31:0] tgt_x, tgt_y, tgt_z;
   } basis_type;

   // camera state mirror and basis calculation
   class camera_scoreboard;
      logic [30:0]        offset;
      logic signed [31:0] height;
      logic signed [31:0] cam [3];
      logic [15:0]        yaw, heading;
      logic signed [15:0] pitch;
      basis_type          pending [$];
      int                 errors;

      function new();
         offset = fcb_pkg::OffsetReset;
         height = fcb_pkg::HeightReset;
         foreach (cam[i]) cam[i] = 0;
         yaw = 0;
         heading = 0;
         pitch = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [fcb_pkg::CsrAddrWidth-1:0] idx, logic [31:0] val);
         if (idx == fcb_pkg::RegOffset) offset = val[30:0];
         else height = val;
      endfunction

      function longint asr(longint v, int n);
         return v >>> n;
      endfunction

      function longint sat(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint unit_clamp(longint v);
         if (v > 16384) return 16384;
         if (v < -16384) return -16384;
         return v;
      endfunction

      function void trig(logic [15:0] ang, output longint sn, output longint cs);
         int atans [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
         logic [15:0] a, rr;
         logic [1:0]  quad;
         longint x, y, z, cx, sy, dx, dy;
         a = ang;
         quad = 2'((a + 16'd8192) >> 14);
         rr = a - {quad, 14'd0};
         if (rr == 0) begin
            cx = 16384;
            sy = 0;
         end else begin
            x = 652032874;
            y = 0;
            z = longint'($signed(rr));
            for (int i = 0; i < 15; i++) begin
               dx = asr(y, i);
               dy = asr(x, i);
               if (z >= 0) begin
                  x -= dx; y += dy; z -= atans[i];
               end else begin
                  x += dx; y -= dy; z += atans[i];
               end
            end
            cx = unit_clamp(asr(x + 32768, 16));
            sy = unit_clamp(asr(y + 32768, 16));
         end
         case (quad)
            2'd0: begin cs = cx; sn = sy; end
            2'd1: begin cs = -sy; sn = cx; end
            2'd2: begin cs = -cx; sn = -sy; end
            default: begin cs = sy; sn = -cx; end
         endcase
      endfunction

      function longint mq(longint a, longint b);
         return asr(a * b + 8192, 14);
      endfunction

      function void note_word(logic kind, logic [fcb_pkg::ReqDataWidth-1:0] d);
         longint sh, ch, sa, ca, sp, cp, dv [3], uv [3];
         basis_type b;
         if (kind == 1'b0) begin
            heading = d[79:64];
            trig(heading, sh, ch);
            cam[0] = sat(longint'($signed(d[31:0])) - asr(longint'(offset) * ch + 8192, 14));
            cam[1] = height;
            cam[2] = sat(longint'($signed(d[63:32])) - asr(longint'(offset) * sh + 8192, 14));
         end else begin
            yaw = d[95:80];
            pitch = d[111:96];
         end
         trig(yaw + heading, sa, ca);
         trig(pitch, sp, cp);
         dv[0] = mq(ca, cp);
         dv[1] = sp;
         dv[2] = mq(sa, cp);
         if (cp == 0) begin
            uv = '{0, 0, 0};
         end else if (cp > 0) begin
            uv = '{-mq(ca, sp), cp, -mq(sa, sp)};
         end else begin
            uv = '{mq(ca, sp), -cp, mq(sa, sp)};
         end
         b.pos_x = cam[0]; b.pos_y = cam[1]; b.pos_z = cam[2];
         b.dir_x = dv[0]; b.dir_y = dv[1]; b.dir_z = dv[2];
         b.up_x = uv[0]; b.up_y = uv[1]; b.up_z = uv[2];
         b.tgt_x = sat(longint'(cam[0]) + dv[0] * 4);
         b.tgt_y = sat(longint'(cam[1]) + dv[1] * 4);
         b.tgt_z = sat(longint'(cam[2]) + dv[2] * 4);
         pending.push_back(b);
      endfunction

      function void check_word(logic [fcb_pkg::RspDataWidth-1:0] d);
         basis_type got, want;
         got.pos_x = d[31:0]; got.pos_y = d[63:32]; got.pos_z = d[95:64];
         got.dir_x = d[111:96]; got.dir_y = d[127:112]; got.dir_z = d[143:128];
         got.up_x = d[159:144]; got.up_y = d[175:160]; got.up_z = d[191:176];
         got.tgt_x = d[223:192]; got.tgt_y = d[255:224]; got.tgt_z = d[287:256];
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", d);
            return;
         end
         want = pending.pop_front();
         if (got != want) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: expected pos %0d %0d %0d dir %0d %0d %0d up %0d %0d %0d",
                        want.pos_x, want.pos_y, want.pos_z, want.dir_x, want.dir_y,
                        want.dir_z, want.up_x, want.up_y, want.up_z);
               $display("          target %0d %0d %0d", want.tgt_x, want.tgt_y, want.tgt_z);
               $display("   actual pos %0d %0d %0d dir %0d %0d %0d up %0d %0d %0d",
                        got.pos_x, got.pos_y, got.pos_z, got.dir_x, got.dir_y,
                        got.dir_z, got.up_x, got.up_y, got.up_z);
               $display("          target %0d %0d %0d", got.tgt_x, got.tgt_y, got.tgt_z);
            end
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [fcb_pkg::ReqDataWidth-1:0]    req_tdata = '0;
   logic                                req_tuser = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [fcb_pkg::RspDataWidth-1:0]    rsp_tdata;
   logic                                csr_we = 1'b0;
   logic [fcb_pkg::CsrAddrWidth-1:0]    csr_addr = '0;
   logic [fcb_pkg::CsrDataWidth-1:0]    csr_wdata = '0;

   camera_scoreboard board = new();
   bit   hold_rsp = 1'b0;
   int   burst_left = 0;

   always #4 clock = ~clock;

   follow_camera_basis u_dut (.*);

   // receiver: stalls on its own pattern, plus one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
      rsp_tready <= !hold_rsp && ($urandom_range(0, 3) != 0 || $urandom_range(0, 1) == 1);
   end

   task automatic send_word(logic kind, logic [fcb_pkg::ReqDataWidth-1:0] d);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 150)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      board.note_word(kind, d);
   endtask

   task automatic send_move(logic [31:0] x, logic [31:0] z, logic [15:0] h);
      send_word(1'b0, {32'd0, h, z, x});
   endtask

   task automatic send_look(logic [15:0] y, logic [15:0] p);
      send_word(1'b1, {p, y, 16'd0, 32'd0, 32'd0});
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(logic [fcb_pkg::CsrAddrWidth-1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(idx, val);
   endtask

   function automatic logic [15:0] rand_pitch();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'($urandom_range(16380, 16388));
         3: return 16'($urandom());
         default: return 16'($signed(17'($urandom_range(0, 32768)) - 17'sd16384));
      endcase
   endfunction

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, both kinds, degenerate and past-vertical pitch
      send_look(16'd0, 16'd0);
      send_move(32'd0, 32'd0, 16'd0);
      send_move(32'h7fffffff, 32'h7fffffff, 16'd32768);
      send_move(32'h80000000, 32'h80000000, 16'd0);
      send_move(32'h7fffffff, 32'h80000000, 16'd16384);
      send_move(32'hffffffff, 32'h00010000, 16'hffff);
      send_look(16'hffff, 16'sd16384);
      send_look(16'd8192, -16'sd16384);
      send_look(16'd49152, 16'sd8192);
      send_look(16'd16384, 16'h8000);
      send_look(16'd8191, 16'h7fff);
      send_look(16'd24576, 16'sd20000);
      send_move(32'h12345678, 32'hedcba987, 16'd8192);
      send_look(16'd100, -16'sd100);
      drain();

      write_reg(fcb_pkg::RegOffset, 32'h7fffffff);
      write_reg(fcb_pkg::RegHeight, 32'h80000000);
      send_move(32'h80000000, 32'h7fffffff, 16'd40000);
      send_move(32'h7fffffff, 32'h80000000, 16'd8000);
      send_look(16'd300, 16'sd16384);
      send_move(32'd0, 32'd0, 16'd0);
      drain();

      write_reg(fcb_pkg::RegOffset, 32'd0);
      write_reg(fcb_pkg::RegHeight, 32'h7fffffff);
      send_move(32'h7ffffffe, 32'h7ffffffe, 16'd12345);
      send_look(16'd0, 16'sd4096);
      drain();

      // long receiver hold-off while words keep coming
      hold_rsp = 1'b1;
      fork
         begin
            for (int i = 0; i < 6; i++) begin
               if ($urandom_range(0, 1)) send_move(rand_pos(), rand_pos(), 16'($urandom()));
               else send_look(16'($urandom()), rand_pitch());
            end
            req_tvalid <= 1'b0;
         end
         begin
            repeat (2000) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_reg(fcb_pkg::RegOffset,
                   phase == 3 ? 32'd231702 : 32'({1'b0, $urandom()} >> $urandom_range(0, 31)));
         write_reg(fcb_pkg::RegHeight, $urandom());
         for (int i = 0; i < NumRandom / 4; i++) begin
            if ($urandom_range(0, 1)) send_move(rand_pos(), rand_pos(), 16'($urandom()));
            else send_look(16'($urandom()), rand_pitch());
         end
         drain();
      end

      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("FAILURE");
      $finish;
   end

endmodule
